[src/gpio_pkg.sv]
package gpio_pkg;

    localparam int GPIO_PORT_W     = 16;
    localparam int GPIO_WORD_W     = 32;
    localparam int GPIO_SEL_W      = 4;
    localparam int GPIO_PIN_COUNT  = 16;
    localparam int GPIO_KEY_BIT    = 16;
    localparam int GPIO_AF_PINS    = 8;

    typedef enum logic [GPIO_SEL_W-1:0] {
        SEL_MODE     = 4'd0,
        SEL_OTYPE    = 4'd1,
        SEL_SPEED    = 4'd2,
        SEL_PULL     = 4'd3,
        SEL_INPUT    = 4'd4,
        SEL_OUTPUT   = 4'd5,
        SEL_SETRESET = 4'd6,
        SEL_LOCK     = 4'd7,
        SEL_AFLOW    = 4'd8,
        SEL_AFHIGH   = 4'd9
    } t_reg_sel;

    typedef enum logic {
        ACT_READ  = 1'b0,
        ACT_WRITE = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        KEY_WAIT   = 2'd0,
        KEY_FIRST  = 2'd1,
        KEY_SECOND = 2'd2
    } t_key_step;

    // Write request toward the lock sequencer.
    typedef struct packed {
        logic                   strobe;
        logic                   key;
        logic [GPIO_PORT_W-1:0] mask;
    } t_lock_wr;

    // Lock register contents.
    typedef struct packed {
        logic [GPIO_PORT_W-1:0] locked_pins;
        logic                   done;
    } t_lock_status;

    // Each pin bit becomes a 2-bit field of ones.
    function automatic logic [GPIO_WORD_W-1:0] spread2(input logic [GPIO_PORT_W-1:0] m);
        logic [GPIO_WORD_W-1:0] r;
        r = '0;
        for (int i = 0; i < GPIO_PORT_W; i++) begin
            r[2*i +: 2] = {2{m[i]}};
        end
        return r;
    endfunction

    // Each of eight pin bits becomes a 4-bit field of ones.
    function automatic logic [GPIO_WORD_W-1:0] spread4(input logic [GPIO_AF_PINS-1:0] m);
        logic [GPIO_WORD_W-1:0] r;
        r = '0;
        for (int i = 0; i < GPIO_AF_PINS; i++) begin
            r[4*i +: 4] = {4{m[i]}};
        end
        return r;
    endfunction

endpackage

[src/gpio_req_if.sv]
interface gpio_req_if import gpio_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic                   action;
    logic [GPIO_SEL_W-1:0]  reg_select;
    logic [GPIO_WORD_W-1:0] write_data;
    logic [GPIO_PORT_W-1:0] pin_in;

    modport source (output valid, action, reg_select, write_data, pin_in, input ready);
    modport sink   (input valid, action, reg_select, write_data, pin_in, output ready);
endinterface

[src/gpio_rsp_if.sv]
interface gpio_rsp_if import gpio_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [GPIO_WORD_W-1:0] read_data;
    logic [GPIO_PORT_W-1:0] pin_out;
    logic                   lock_engaged;

    modport source (output valid, read_data, pin_out, lock_engaged, input ready);
    modport sink   (input valid, read_data, pin_out, lock_engaged, output ready);
endinterface

[src/gpio_lock_ctrl.sv]
module gpio_lock_ctrl import gpio_pkg::*; #(
    parameter int PIN_COUNT = GPIO_PIN_COUNT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_lock_wr     i_wr,
    output t_lock_status o_status,
    output t_lock_status o_status_nxt
);

    localparam logic [GPIO_PORT_W-1:0] PRESENT =
        GPIO_PORT_W'((32'd1 << PIN_COUNT) - 32'd1);

    t_key_step              r_step, n_step;
    logic [GPIO_PORT_W-1:0] r_mask, n_mask;
    logic [GPIO_PORT_W-1:0] r_locked, n_locked;
    logic                   r_done, n_done;
    logic                   w_same;

    assign w_same = (i_wr.mask == r_mask);

    // Key sequence: set, clear with the same mask, set with the same mask.
    // A step that does not match restarts, and a set key opens a new sequence.
    always_comb begin
        n_step   = r_step;
        n_mask   = r_mask;
        n_locked = r_locked;
        n_done   = r_done;
        if (i_wr.strobe && !r_done) begin
            n_locked = i_wr.mask & PRESENT;
            unique case (r_step)
                KEY_FIRST: begin
                    if (!i_wr.key && w_same) begin
                        n_step = KEY_SECOND;
                    end else if (i_wr.key) begin
                        n_step = KEY_FIRST;
                        n_mask = i_wr.mask;
                    end else begin
                        n_step = KEY_WAIT;
                    end
                end
                KEY_SECOND: begin
                    if (i_wr.key && w_same) begin
                        n_done = 1'b1;
                        n_step = KEY_WAIT;
                    end else if (i_wr.key) begin
                        n_step = KEY_FIRST;
                        n_mask = i_wr.mask;
                    end else begin
                        n_step = KEY_WAIT;
                    end
                end
                default: begin
                    if (i_wr.key) begin
                        n_step = KEY_FIRST;
                        n_mask = i_wr.mask;
                    end else begin
                        n_step = KEY_WAIT;
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_status.locked_pins     = r_locked;
        o_status.done            = r_done;
        o_status_nxt.locked_pins = n_locked;
        o_status_nxt.done        = n_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= KEY_WAIT;
            r_mask   <= '0;
            r_locked <= '0;
            r_done   <= 1'b0;
        end else begin
            r_step   <= n_step;
            r_mask   <= n_mask;
            r_locked <= n_locked;
            r_done   <= n_done;
        end
    end

endmodule

[src/gpio_port_register_block.sv]
// GPIO port register block for one port of up to sixteen pins.
//
// Requests arrive on i_req (valid/ready): action selects read or write,
// reg_select picks the register, write_data carries the write word and
// pin_in the current pin levels. Every request yields exactly one response
// on o_rsp with read_data, the output levels after the access (pin_out) and
// the lock status (lock_engaged).
//
// The request is captured in an input register, and the register update
// and read mux run once the response register is free and land in it.
// Throughput is one request per clock while o_rsp.ready stays high; the
// input register and the response register set that figure.
//
// Synchronous reset clears every port register, the lock and the key
// sequence. When the receiver holds o_rsp.ready low, the response stays
// put and one further request may wait in the input register; i_req.ready
// drops only when both stages are full.
module gpio_port_register_block import gpio_pkg::*; #(
    parameter int PIN_COUNT = GPIO_PIN_COUNT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gpio_req_if.sink  i_req,
    gpio_rsp_if.source o_rsp
);

    localparam logic [GPIO_PORT_W-1:0] PRESENT =
        GPIO_PORT_W'((32'd1 << PIN_COUNT) - 32'd1);

    // Input register.
    logic                   r_req_valid;
    logic                   r_action;
    logic [GPIO_SEL_W-1:0]  r_sel;
    logic [GPIO_WORD_W-1:0] r_data;
    logic [GPIO_PORT_W-1:0] r_pins;

    // Response register.
    logic                   r_rsp_valid;
    logic [GPIO_WORD_W-1:0] r_rd;
    logic [GPIO_PORT_W-1:0] r_pin_out;
    logic                   r_lock_eng;

    // Port state.
    logic [GPIO_WORD_W-1:0] r_mode, n_mode;
    logic [GPIO_PORT_W-1:0] r_otype, n_otype;
    logic [GPIO_WORD_W-1:0] r_speed, n_speed;
    logic [GPIO_WORD_W-1:0] r_pull, n_pull;
    logic [GPIO_WORD_W-1:0] r_aflow, n_aflow;
    logic [GPIO_WORD_W-1:0] r_afhigh, n_afhigh;
    logic [GPIO_PORT_W-1:0] r_odr, n_odr;

    logic                   w_adv;
    logic                   w_take;
    logic                   w_exec;
    logic                   w_wr;
    logic [GPIO_PORT_W-1:0] w_open;
    logic [GPIO_WORD_W-1:0] w_rd;
    t_lock_wr               w_lock_wr;
    t_lock_status           w_lock;
    t_lock_status           w_lock_nxt;

    // The response register frees up when it is empty or being taken.
    assign w_adv       = !r_rsp_valid || o_rsp.ready;
    assign i_req.ready = !r_req_valid || w_adv;
    assign w_take      = i_req.valid && i_req.ready;
    assign w_exec      = r_req_valid && w_adv;
    assign w_wr        = w_exec && (r_action == ACT_WRITE);

    // Pins whose configuration may still change.
    assign w_open = PRESENT & ~(w_lock.done ? w_lock.locked_pins : '0);

    assign w_lock_wr.strobe = w_wr && (r_sel == SEL_LOCK);
    assign w_lock_wr.key    = r_data[GPIO_KEY_BIT];
    assign w_lock_wr.mask   = r_data[GPIO_PORT_W-1:0];

    gpio_lock_ctrl #(
        .PIN_COUNT (PIN_COUNT)
    ) u_lock (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (w_lock_wr),
        .o_status     (w_lock),
        .o_status_nxt (w_lock_nxt)
    );

    // Register writes. Configuration fields of locked pins keep their value;
    // the output data register is never locked. For set/reset the set half
    // is applied last so it wins over a clear of the same pin.
    always_comb begin
        n_mode   = r_mode;
        n_otype  = r_otype;
        n_speed  = r_speed;
        n_pull   = r_pull;
        n_aflow  = r_aflow;
        n_afhigh = r_afhigh;
        n_odr    = r_odr;
        if (w_wr) begin
            unique case (r_sel)
                SEL_MODE: begin
                    n_mode = (r_mode & ~spread2(w_open)) | (r_data & spread2(w_open));
                end
                SEL_OTYPE: begin
                    n_otype = (r_otype & ~w_open) | (r_data[GPIO_PORT_W-1:0] & w_open);
                end
                SEL_SPEED: begin
                    n_speed = (r_speed & ~spread2(w_open)) | (r_data & spread2(w_open));
                end
                SEL_PULL: begin
                    n_pull = (r_pull & ~spread2(w_open)) | (r_data & spread2(w_open));
                end
                SEL_OUTPUT: begin
                    n_odr = r_data[GPIO_PORT_W-1:0] & PRESENT;
                end
                SEL_SETRESET: begin
                    n_odr = ((r_odr & ~r_data[GPIO_WORD_W-1:GPIO_PORT_W])
                            | r_data[GPIO_PORT_W-1:0]) & PRESENT;
                end
                SEL_AFLOW: begin
                    n_aflow = (r_aflow & ~spread4(w_open[GPIO_AF_PINS-1:0]))
                            | (r_data & spread4(w_open[GPIO_AF_PINS-1:0]));
                end
                SEL_AFHIGH: begin
                    n_afhigh = (r_afhigh & ~spread4(w_open[GPIO_PORT_W-1:GPIO_AF_PINS]))
                             | (r_data & spread4(w_open[GPIO_PORT_W-1:GPIO_AF_PINS]));
                end
                default: begin
                end
            endcase
        end
    end

    // Read mux; writes, set/reset reads and unused selectors return zero.
    // The lock register reads the locked pins low and the lock bit above them.
    always_comb begin
        w_rd = '0;
        if (r_action == ACT_READ) begin
            unique case (r_sel)
                SEL_MODE:   w_rd = r_mode;
                SEL_OTYPE:  w_rd = GPIO_WORD_W'(r_otype);
                SEL_SPEED:  w_rd = r_speed;
                SEL_PULL:   w_rd = r_pull;
                SEL_INPUT:  w_rd = GPIO_WORD_W'(r_pins & PRESENT);
                SEL_OUTPUT: w_rd = GPIO_WORD_W'(r_odr);
                SEL_LOCK:   w_rd = GPIO_WORD_W'({w_lock.done, w_lock.locked_pins});
                SEL_AFLOW:  w_rd = r_aflow;
                SEL_AFHIGH: w_rd = r_afhigh;
                default:    w_rd = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_rsp_valid <= 1'b0;
            r_mode      <= '0;
            r_otype     <= '0;
            r_speed     <= '0;
            r_pull      <= '0;
            r_aflow     <= '0;
            r_afhigh    <= '0;
            r_odr       <= '0;
        end else begin
            if (w_take) begin
                r_req_valid <= 1'b1;
            end else if (w_adv) begin
                r_req_valid <= 1'b0;
            end
            if (w_exec) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
            r_mode   <= n_mode;
            r_otype  <= n_otype;
            r_speed  <= n_speed;
            r_pull   <= n_pull;
            r_aflow  <= n_aflow;
            r_afhigh <= n_afhigh;
            r_odr    <= n_odr;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_action <= i_req.action;
            r_sel    <= i_req.reg_select;
            r_data   <= i_req.write_data;
            r_pins   <= i_req.pin_in;
        end
        if (w_exec) begin
            r_rd       <= w_rd;
            r_pin_out  <= n_odr;
            r_lock_eng <= w_lock_nxt.done;
        end
    end

    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.read_data    = r_rd;
    assign o_rsp.pin_out      = r_pin_out;
    assign o_rsp.lock_engaged = r_lock_eng;

    // Once engaged, the lock holds until reset.
    a_lock_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lock.done |=> w_lock.done)
        else $error("lock released without reset");

    // Locked pin set is frozen once the lock is engaged.
    a_lock_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lock.done |=> $stable(w_lock.locked_pins))
        else $error("locked pin set changed after lock");

    // Locked mode fields never change.
    a_mode_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lock.done |=> ((r_mode & spread2(w_lock.locked_pins))
                        == ($past(r_mode) & spread2(w_lock.locked_pins))))
        else $error("mode field of a locked pin changed");

    // Absent pins never drive a level.
    a_absent_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_odr & ~PRESENT) == '0)
        else $error("output level set on an absent pin");

    // A held response is never overwritten.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && !o_rsp.ready) |-> !w_exec)
        else $error("response overwritten while stalled");

endmodule
